>>> hw/rtl/vkol_pkg.sv
// Shared constants and types of the value-keyed ordered list.
// Used by the channel interfaces and by value_keyed_ordered_list_core.
package vkol_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed widths of the beat fields
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int EXT_W    = 64;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_FRONT  = 3'd0,
        OP_BACK   = 3'd1,
        OP_AFTER  = 3'd2,
        OP_DELETE = 3'd3,
        OP_MODIFY = 3'd4,
        OP_FIND   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage

>>> hw/rtl/vkol_cmd_if.sv
// Command channel of the value-keyed ordered list: valid/ready plus one operation.
// Depends on vkol_pkg for the field widths.
interface vkol_cmd_if;
    import vkol_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] search_key;
    logic signed [KEY_W-1:0] new_value;

    modport source (output valid, op, search_key, new_value, input ready);
    modport sink   (input valid, op, search_key, new_value, output ready);

endinterface

>>> hw/rtl/vkol_rsp_if.sv
// Response channel of the value-keyed ordered list: valid/ready plus one result.
// Depends on vkol_pkg for the field widths.
interface vkol_rsp_if;
    import vkol_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  element_count;

    modport source (output valid, status, position, element_count, input ready);
    modport sink   (input valid, status, position, element_count, output ready);

endinterface

>>> hw/rtl/value_keyed_ordered_list_core.sv
// Bounded ordered list of signed values kept in one synchronous memory.
// Depends on vkol_pkg, vkol_cmd_if and vkol_rsp_if.
//
//   channel | dir | beat fields                        | accepted when
//   --------+-----+------------------------------------+--------------------
//   cmd     | in  | op, search_key, new_value          | cmd.valid & ready
//   rsp     | out | status, position, element_count    | rsp.valid & ready
//
// One command at a time. Append, refused and trivial commands go from S_IDLE
// straight to S_WRAP, which loads the response register. All others walk the list
// through the single read port in S_SCAN, one entry per cycle; an inserted value
// then has S_TAIL write the tail. Find and modify stop at the first match.
// Reset empties the list at once; the memory itself is not cleared.
// A held response stalls the next command only until it leaves the output register.
module value_keyed_ordered_list_core #(
    parameter int CAPACITY   = vkol_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = vkol_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vkol_cmd_if.sink      cmd,
    vkol_rsp_if.source    rsp
);
    import vkol_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_WRAP
    } state_t;

    // control
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  pv_reg, pv_next;
    logic                  found_reg, found_next;
    logic                  rsp_valid_reg, rsp_valid_next;

    // payload
    op_t                   op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] carry_reg, carry_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    status_t               stat_reg, stat_next;
    logic [IDX_W-1:0]      dv_idx_reg, dv_idx_next;
    status_t               rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]      rsp_position_reg, rsp_position_next;
    logic [COUNT_W-1:0]    rsp_count_reg, rsp_count_next;

    // memory
    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;

    logic [EXT_W-1:0]      key_ext;
    logic [EXT_W-1:0]      val_ext;
    logic                  full;
    logic                  last;
    logic                  out_free;

    assign key_ext  = {{(EXT_W-KEY_W){cmd.search_key[KEY_W-1]}}, cmd.search_key};
    assign val_ext  = {{(EXT_W-KEY_W){cmd.new_value[KEY_W-1]}}, cmd.new_value};
    assign full     = (occ_reg == CAP_CNT);
    assign last     = pv_reg &&
                      ((CNT_W+1)'(dv_idx_reg) + (CNT_W+1)'(1) == (CNT_W+1)'(occ_reg));
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.position      = rsp_position_reg;
    assign rsp.element_count = rsp_count_reg;

    always_comb
    begin
        state_next        = state_reg;
        occ_next          = occ_reg;
        rd_idx_next       = rd_idx_reg;
        pv_next           = 1'b0;
        found_next        = found_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        carry_next        = carry_reg;
        pos_next          = pos_reg;
        stat_next         = stat_reg;
        dv_idx_next       = dv_idx_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_status_next   = rsp_status_reg;
        rsp_position_next = rsp_position_reg;
        rsp_count_next    = rsp_count_reg;
        rd_en             = 1'b0;
        rd_addr           = rd_idx_reg[IDX_W-1:0];
        wr_en             = 1'b0;
        wr_addr           = occ_reg[IDX_W-1:0];
        wr_data           = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next     = op_t'(cmd.op);
                    key_next    = key_ext[DATA_WIDTH-1:0];
                    val_next    = val_ext[DATA_WIDTH-1:0];
                    carry_next  = val_ext[DATA_WIDTH-1:0];
                    pos_next    = '0;
                    stat_next   = ST_OK;
                    found_next  = 1'b0;
                    rd_idx_next = '0;
                    state_next  = S_WRAP;
                    priority if (cmd.op > OP_FIND)
                    begin
                        stat_next = ST_NOT_FOUND;
                    end
                    else if (full && (cmd.op == OP_FRONT || cmd.op == OP_BACK ||
                                      cmd.op == OP_AFTER))
                    begin
                        stat_next = ST_FULL;
                    end
                    else if (cmd.op == OP_BACK || (cmd.op == OP_FRONT && occ_reg == '0))
                    begin
                        // append straight to the tail
                        wr_en    = 1'b1;
                        wr_addr  = occ_reg[IDX_W-1:0];
                        wr_data  = val_ext[DATA_WIDTH-1:0];
                        pos_next = occ_reg[IDX_W-1:0];
                        occ_next = CNT_W'(occ_reg + 1'b1);
                    end
                    else if (occ_reg == '0)
                    begin
                        stat_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        // scan the list; a front insert ripples from entry 0 with no search
                        state_next = S_SCAN;
                        found_next = (cmd.op == OP_FRONT);
                    end
                end
            end

            S_SCAN:
            begin
                // read one entry ahead; a written entry is never read again
                if (rd_idx_reg != occ_reg)
                begin
                    rd_en       = 1'b1;
                    pv_next     = 1'b1;
                    dv_idx_next = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = CNT_W'(rd_idx_reg + 1'b1);
                end
                if (pv_reg)
                begin
                    if (found_reg)
                    begin
                        wr_en = 1'b1;
                        if (op_reg == OP_DELETE)
                        begin
                            // close the gap: move each entry down by one
                            wr_addr = dv_idx_reg - IDX_W'(1);
                            wr_data = rd_data_reg;
                        end
                        else
                        begin
                            // open the gap: write the carried value, carry the old one
                            wr_addr    = dv_idx_reg;
                            wr_data    = carry_reg;
                            carry_next = rd_data_reg;
                        end
                    end
                    else if (rd_data_reg == key_reg)
                    begin
                        pos_next = dv_idx_reg;
                        unique case (op_reg)
                            OP_FIND:
                            begin
                                state_next = S_WRAP;
                            end
                            OP_MODIFY:
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = dv_idx_reg;
                                wr_data    = val_reg;
                                state_next = S_WRAP;
                            end
                            OP_DELETE:
                            begin
                                found_next = 1'b1;
                            end
                            OP_AFTER:
                            begin
                                found_next = 1'b1;
                                pos_next   = dv_idx_reg + IDX_W'(1);
                                carry_next = val_reg;
                            end
                            default:
                            begin
                                state_next = S_WRAP;
                            end
                        endcase
                    end

                    if (last && state_next == S_SCAN)
                    begin
                        priority if (!found_next)
                        begin
                            stat_next  = ST_NOT_FOUND;
                            pos_next   = '0;
                            state_next = S_WRAP;
                        end
                        else if (op_reg == OP_DELETE)
                        begin
                            occ_next   = CNT_W'(occ_reg - 1'b1);
                            state_next = S_WRAP;
                        end
                        else
                        begin
                            state_next = S_TAIL;
                        end
                    end
                end
                if (state_next != S_SCAN)
                begin
                    pv_next = 1'b0;
                end
            end

            S_TAIL:
            begin
                wr_en      = 1'b1;
                wr_addr    = occ_reg[IDX_W-1:0];
                wr_data    = carry_reg;
                occ_next   = CNT_W'(occ_reg + 1'b1);
                state_next = S_WRAP;
            end

            S_WRAP:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_status_next   = stat_reg;
                    rsp_position_next = POS_W'(pos_reg);
                    rsp_count_next    = COUNT_W'(occ_reg);
                    state_next        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            occ_reg          <= '0;
            rd_idx_reg       <= '0;
            pv_reg           <= 1'b0;
            found_reg        <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            op_reg           <= OP_FRONT;
            key_reg          <= '0;
            val_reg          <= '0;
            carry_reg        <= '0;
            pos_reg          <= '0;
            stat_reg         <= ST_OK;
            dv_idx_reg       <= '0;
            rsp_status_reg   <= ST_OK;
            rsp_position_reg <= '0;
            rsp_count_reg    <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            occ_reg          <= occ_next;
            rd_idx_reg       <= rd_idx_next;
            pv_reg           <= pv_next;
            found_reg        <= found_next;
            rsp_valid_reg    <= rsp_valid_next;
            op_reg           <= op_next;
            key_reg          <= key_next;
            val_reg          <= val_next;
            carry_reg        <= carry_next;
            pos_reg          <= pos_next;
            stat_reg         <= stat_next;
            dv_idx_reg       <= dv_idx_next;
            rsp_status_reg   <= rsp_status_next;
            rsp_position_reg <= rsp_position_next;
            rsp_count_reg    <= rsp_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CAP_CNT)
        else $error("element count above capacity");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == $past(occ_reg)) ||
        (occ_reg == CNT_W'($past(occ_reg) + 1'b1)) ||
        (CNT_W'(occ_reg + 1'b1) == $past(occ_reg)))
        else $error("element count moved by more than one");

    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= occ_reg))
        else $error("write beyond the tail of the list");

    a_rd_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (CNT_W'(dv_idx_reg) < occ_reg))
        else $error("read data from outside the list");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRAP && out_free && stat_reg == ST_FULL) |-> full)
        else $error("full status while the list has room");

endmodule

>>> tb/value_keyed_ordered_list_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of value_keyed_ordered_list_core: a scripted opening, then phased
// random operations, checked against scripted beats or a queue-based shadow. Depends on vkol_pkg,
// vkol_cmd_if, vkol_rsp_if and the core itself.
module value_keyed_ordered_list_core_test;
    import vkol_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_ODD = 32'sh5555_5555;
    localparam logic signed [KEY_W-1:0] KEY_EVEN = 32'shaaaa_aaaa;

    localparam logic signed [KEY_W-1:0] VALUE_POOL [8] = '{
        32'sd0, -32'sd1, 32'sd1, KEY_MIN, KEY_MAX, KEY_ODD, KEY_EVEN, 32'sd42
    };

    localparam int RANDOM_ITEMS = 1880;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 80;
    localparam int LONG_HOLD    = 400;
    localparam int MISMATCH_SHOW = 10;

    typedef struct packed {
        status_t            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] element_count;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] value;
        bit               typed;
        list_result_t     want;
    } script_row_t;

    typedef enum int {PH_MIX, PH_FILL, PH_DRAIN} phase_kind_t;

    localparam list_result_t PREDICTED = '0;

    // rows with typed=1 carry their own expected beat, the rest go to the shadow list
    localparam int SCRIPT_LEN = 24;
    localparam script_row_t OPENING_SCRIPT [SCRIPT_LEN] = '{
        '{OP_FIND,     32'sd0,   32'sd0,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_DELETE,   32'sd0,   32'sd0,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_MODIFY,   32'sd5,   32'sd9,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_AFTER,    32'sd5,   32'sd1,   1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_UNUSED_6, KEY_MAX,  KEY_MIN,  1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_UNUSED_7, KEY_MIN,  KEY_MAX,  1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0}},
        '{OP_FRONT,    32'sd0,   KEY_MIN,  1'b1, '{ST_OK,        6'd0, 7'd1}},
        '{OP_BACK,     32'sd0,   KEY_MAX,  1'b1, '{ST_OK,        6'd1, 7'd2}},
        '{OP_BACK,     32'sd0,   -32'sd1,  1'b1, '{ST_OK,        6'd2, 7'd3}},
        '{OP_FRONT,    32'sd0,   32'sd0,   1'b1, '{ST_OK,        6'd0, 7'd4}},
        '{OP_AFTER,    KEY_MAX,  KEY_MAX,  1'b0, PREDICTED},
        '{OP_FIND,     KEY_MAX,  32'sd0,   1'b0, PREDICTED},
        '{OP_MODIFY,   -32'sd1,  KEY_MIN,  1'b0, PREDICTED},
        '{OP_FIND,     KEY_MIN,  32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   KEY_MIN,  32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   32'sd0,   32'sd0,   1'b0, PREDICTED},
        '{OP_AFTER,    KEY_MIN,  KEY_ODD,  1'b0, PREDICTED},
        '{OP_DELETE,   KEY_ODD,  32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   KEY_EVEN, 32'sd0,   1'b0, PREDICTED},
        '{OP_UNUSED_6, KEY_MAX,  KEY_EVEN, 1'b0, PREDICTED},
        '{OP_FIND,     32'sd1,   32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   KEY_MAX,  32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   KEY_MAX,  32'sd0,   1'b0, PREDICTED},
        '{OP_DELETE,   KEY_MIN,  32'sd0,   1'b0, PREDICTED}
    };

    logic clk;
    logic rst_n;

    vkol_cmd_if cmd_ch ();
    vkol_rsp_if rsp_ch ();

    value_keyed_ordered_list_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    logic signed [KEY_W-1:0] shadow_list [$];
    list_result_t            pending_results [$];

    bit calm_phase;
    bit long_hold_done;
    int items_sent;
    int results_seen;
    int mismatch_count;
    int peak_fill;
    int status_tally [3];

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short idles, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 96) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Shadow of the list: apply one operation and return the beat it must produce.
    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic signed [KEY_W-1:0] key,
                                                   logic signed [KEY_W-1:0] value);
        list_result_t res;
        int hit;
        bit full;
        res.status   = ST_OK;
        res.position = '0;
        full = shadow_list.size() >= CAPACITY_DEF;
        hit = -1;
        for (int i = 0; i < shadow_list.size(); i++)
        begin
            if (hit < 0 && shadow_list[i] == key)
                hit = i;
        end
        case (op)
            OP_FRONT:
            begin
                if (full)
                    res.status = ST_FULL;
                else
                    shadow_list.push_front(value);
            end
            OP_BACK:
            begin
                if (full)
                    res.status = ST_FULL;
                else
                begin
                    res.position = POS_W'(shadow_list.size());
                    shadow_list.push_back(value);
                end
            end
            OP_AFTER:
            begin
                // full check wins over the key search
                if (full)
                    res.status = ST_FULL;
                else if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    shadow_list.insert(hit + 1, value);
                    res.position = POS_W'(hit + 1);
                end
            end
            OP_DELETE, OP_MODIFY, OP_FIND:
            begin
                if (hit < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    res.position = POS_W'(hit);
                    if (op == OP_DELETE)
                        shadow_list.delete(hit);
                    else if (op == OP_MODIFY)
                        shadow_list[hit] = value;
                end
            end
            default:
                res.status = ST_NOT_FOUND;
        endcase
        res.element_count = COUNT_W'(shadow_list.size());
        if (shadow_list.size() > peak_fill)
            peak_fill = shadow_list.size();
        return res;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(phase_kind_t kind);
        int roll;
        int ins_top;
        int del_top;
        roll = $urandom_range(99);
        case (kind)
            PH_FILL:
            begin
                ins_top = 78;
                del_top = 86;
            end
            PH_DRAIN:
            begin
                ins_top = 15;
                del_top = 70;
            end
            default:
            begin
                ins_top = 45;
                del_top = 65;
            end
        endcase
        if (roll < 3)
            return $urandom_range(1) ? OP_UNUSED_6 : OP_UNUSED_7;
        if (roll < ins_top)
        begin
            case ($urandom_range(2))
                0: return OP_FRONT;
                1: return OP_BACK;
                default: return OP_AFTER;
            endcase
        end
        if (roll < del_top)
            return OP_DELETE;
        return $urandom_range(1) ? OP_MODIFY : OP_FIND;
    endfunction

    // Keys lean on stored values so searches hit; the pool feeds duplicates.
    function automatic logic signed [KEY_W-1:0] pick_word(int list_pct);
        if (shadow_list.size() > 0 && $urandom_range(99) < list_pct)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if ($urandom_range(9) < 4)
            return VALUE_POOL[$urandom_range(7)];
        return $urandom();
    endfunction

    task automatic send_op(input script_row_t row);
        int gap;
        list_result_t predicted;
        gap = calm_phase ? 0 : idle_len();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.op         <= row.op;
        cmd_ch.search_key <= row.key;
        cmd_ch.new_value  <= row.value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predicted = apply_list_op(row.op, row.key, row.value);
        pending_results.push_back(row.typed ? row.want : predicted);
        items_sent++;
    endtask

    // command side: scripted opening, random phases, drain, verdict
    initial begin
        script_row_t row;
        phase_kind_t kind;
        int phase_no;
        int phase_len;
        int list_pct;
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.op         <= OP_FRONT;
        cmd_ch.search_key <= '0;
        cmd_ch.new_value  <= '0;
        calm_phase = 1'b0;
        items_sent = 0;
        peak_fill = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
            send_op(OPENING_SCRIPT[i]);

        phase_no = 0;
        while (items_sent < SCRIPT_LEN + RANDOM_ITEMS)
        begin
            kind = phase_kind_t'(phase_no % 3);
            calm_phase = ($urandom_range(4) == 0);
            phase_len = (kind == PH_FILL) ? $urandom_range(180, 130) : $urandom_range(160, 80);
            list_pct = (kind == PH_DRAIN) ? 90 : 65;
            for (int n = 0; n < phase_len && items_sent < SCRIPT_LEN + RANDOM_ITEMS; n++)
            begin
                row.op    = pick_op(kind);
                row.key   = pick_word(list_pct);
                row.value = pick_word(0);
                row.typed = 1'b0;
                row.want  = PREDICTED;
                send_op(row);
            end
            // hold off after a drain until every outstanding beat is back
            if (kind == PH_DRAIN)
            begin
                cmd_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            phase_no++;
        end

        cmd_ch.valid <= 1'b0;
        calm_phase = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d operations over %0d phases: %0d ok, %0d misses, %0d full refusals.",
                 items_sent, phase_no, status_tally[ST_OK], status_tally[ST_NOT_FOUND],
                 status_tally[ST_FULL]);
        $display("Peak list fill %0d of %0d, %0d mismatches.", peak_fill, CAPACITY_DEF,
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("value_keyed_ordered_list_core verification clean");
        else
            $display("value_keyed_ordered_list_core verification failed");
        $finish;
    end

    // response side: check each beat against the oldest expectation, stall at random
    initial begin
        int hold;
        list_result_t want;
        list_result_t got;
        hold = 0;
        results_seen = 0;
        mismatch_count = 0;
        long_hold_done = 1'b0;
        status_tally = '{0, 0, 0};
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status        = status_t'(rsp_ch.status);
                got.position      = rsp_ch.position;
                got.element_count = rsp_ch.element_count;
                results_seen++;
                if (got.status <= ST_FULL)
                    status_tally[got.status]++;
                if (pending_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MISMATCH_SHOW)
                        $display("[%0t] beat %0d unexpected: st %0d pos %0d cnt %0d",
                                 $realtime, results_seen, got.status, got.position,
                                 got.element_count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MISMATCH_SHOW)
                            $display({"[%0t] beat %0d: expected st %0d pos %0d cnt %0d,",
                                      " got st %0d pos %0d cnt %0d"},
                                     $realtime, results_seen, want.status, want.position,
                                     want.element_count, got.status, got.position,
                                     got.element_count);
                    end
                end
            end
            // one long back-pressure stretch so the held response blocks commands
            if (!long_hold_done && results_seen >= 300)
            begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!calm_phase && $urandom_range(99) < 15)
                    hold = idle_len();
            end
        end
    end

    // watchdog: end the run if nothing moves on either channel for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("No beat for %0d cycles, %0d results still outstanding.", STALL_LIMIT,
                 pending_results.size());
        $display("value_keyed_ordered_list_core verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/vkol_pkg.sv
hw/rtl/vkol_cmd_if.sv
hw/rtl/vkol_rsp_if.sv
hw/rtl/value_keyed_ordered_list_core.sv
tb/value_keyed_ordered_list_core_test.sv
